[sv/fspa_pkg.sv]
`timescale 1ns / 1ps
package fspa_pkg;

   localparam int MAX_SLOTS_DEF    = 1024;
   localparam int HEADER_BYTES_DEF = 16;
   localparam int ALIGN_BYTES_DEF  = 16;

   localparam int DIV_W  = 32;
   localparam int PAY_W  = 22;   // slot_stride rounded up to the alignment
   localparam int SLOT_W = 23;   // header plus payload
   localparam int PROD_W = 62;   // product of two positive 31-bit values

   typedef enum logic [1:0] {
      OP_RESERVE = 2'd0,
      OP_RELEASE = 2'd1,
      OP_CLEAR   = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_BAD          = 3'd1,
      ST_EXHAUSTED    = 3'd2,
      ST_OUTSIDE      = 3'd3,
      ST_MISALIGNED   = 3'd4,
      ST_ALREADY_FREE = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      REG_POOL_BASE   = 2'd0,
      REG_POOL_BYTES  = 2'd1,
      REG_SLOT_STRIDE = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ROUND,
      S_DISPATCH,
      S_RES_CHK,
      S_POP,
      S_ADDR,
      S_ADDR2,
      S_REL_CHK,
      S_REL_WAIT,
      S_REL_MARK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic       latch;
      logic       div_start;
      logic       load_rnd;
      logic       load_pay;
      logic       load_prod;
      logic       load_dist;
      logic       head_read;
      logic       pop;
      logic       bump;
      logic       mark_read;
      logic       mul_addr;
      logic       write_alloc;
      logic       load_addr;
      logic       commit_rel;
      logic       clear;
      logic       out_load;
      status_type code;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       div_done;
      logic       req_bad;
      logic       prod_fits;
      logic       head_valid;
      logic       bump_ok;
      logic       ra_null;
      logic       dist_outside;
      logic       rem_nz;
      logic       idx_outside;
      logic       mark_set;
      logic       out_free;
   } stat_type;

endpackage

[sv/fspa_div.sv]
`timescale 1ns / 1ps
module fspa_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [fspa_pkg::DIV_W-1:0] dividend,
   input  logic [fspa_pkg::DIV_W-1:0] divisor,
   output logic                       busy,
   output logic                       done,
   output logic [fspa_pkg::DIV_W-1:0] quotient,
   output logic [fspa_pkg::DIV_W-1:0] remainder
);
   import fspa_pkg::*;

   localparam int CNT_W = $clog2(DIV_W);

   logic [DIV_W-1:0] rem_ff, rem_in, quo_ff, quo_in, dvs_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DIV_W:0]   rem_sh, diff;

   // one quotient bit per cycle, restoring
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DIV_W-1]};
      diff    = rem_sh - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DIV_W]) begin
            rem_in = diff[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[sv/fspa_ctrl.sv]
`timescale 1ns / 1ps
module fspa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  fspa_pkg::stat_type st,
   output fspa_pkg::cmd_type  cmd
);
   import fspa_pkg::*;

   state_type  state_ff, state_in;
   status_type code_ff, code_in;

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: state_in = S_DISPATCH;
         S_DISPATCH: begin
            state_in = S_DONE;
            case (opcode_type'(st.op))
               OP_RESERVE: begin
                  if (st.req_bad) begin
                     code_in = ST_BAD;
                  end else begin
                     state_in = S_RES_CHK;
                  end
               end
               OP_RELEASE: begin
                  if (st.ra_null) begin
                     code_in = ST_BAD;
                  end else begin
                     state_in = S_REL_CHK;
                  end
               end
               OP_CLEAR: code_in = ST_OK;
               default:  code_in = ST_BAD;
            endcase
         end
         S_RES_CHK: begin
            if (!st.prod_fits) begin
               code_in  = ST_BAD;
               state_in = S_DONE;
            end else if (st.head_valid) begin
               state_in = S_POP;
            end else if (st.bump_ok) begin
               state_in = S_ADDR;
            end else begin
               code_in  = ST_EXHAUSTED;
               state_in = S_DONE;
            end
         end
         S_POP:   state_in = S_ADDR;
         S_ADDR:  state_in = S_ADDR2;
         S_ADDR2: begin
            code_in  = ST_OK;
            state_in = S_DONE;
         end
         S_REL_CHK: begin
            if (st.dist_outside) begin
               code_in  = ST_OUTSIDE;
               state_in = S_DONE;
            end else begin
               state_in = S_REL_WAIT;
            end
         end
         S_REL_WAIT: begin
            if (st.div_done) begin
               if (st.rem_nz) begin
                  code_in  = ST_MISALIGNED;
                  state_in = S_DONE;
               end else if (st.idx_outside) begin
                  code_in  = ST_OUTSIDE;
                  state_in = S_DONE;
               end else begin
                  state_in = S_REL_MARK;
               end
            end
         end
         S_REL_MARK: begin
            code_in  = st.mark_set ? ST_ALREADY_FREE : ST_OK;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (st.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.code   = code_ff;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.latch  = req_tvalid;
         end
         S_ROUND: cmd.load_rnd = 1'b1;
         S_DISPATCH: begin
            cmd.load_pay  = 1'b1;
            cmd.load_prod = 1'b1;
            cmd.load_dist = 1'b1;
            cmd.clear     = (opcode_type'(st.op) == OP_CLEAR);
         end
         S_RES_CHK: begin
            cmd.head_read = st.prod_fits && st.head_valid;
            cmd.bump      = st.prod_fits && !st.head_valid && st.bump_ok;
         end
         S_POP:   cmd.pop = 1'b1;
         S_ADDR: begin
            cmd.mul_addr    = 1'b1;
            cmd.write_alloc = 1'b1;
         end
         S_ADDR2: cmd.load_addr = 1'b1;
         S_REL_CHK: cmd.div_start = !st.dist_outside;
         S_REL_WAIT: cmd.mark_read = st.div_done && !st.rem_nz && !st.idx_outside;
         S_REL_MARK: cmd.commit_rel = !st.mark_set;
         S_DONE:  cmd.out_load = st.out_free;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= ST_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

[sv/fspa_dp.sv]
`timescale 1ns / 1ps
module fspa_dp #(
   parameter int MAX_SLOTS    = fspa_pkg::MAX_SLOTS_DEF,
   parameter int HEADER_BYTES = fspa_pkg::HEADER_BYTES_DEF,
   parameter int ALIGN_BYTES  = fspa_pkg::ALIGN_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   input  logic [1:0]         req_tuser,
   input  logic [95:0]        req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [2:0]         rsp_tuser,
   output logic [31:0]        rsp_tdata,
   input  fspa_pkg::cmd_type  cmd,
   output fspa_pkg::stat_type st
);
   import fspa_pkg::*;

   localparam int IDX_W = $clog2(MAX_SLOTS);
   localparam int BS_W  = IDX_W + 1;
   localparam int HDR   = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
   localparam int MUL_W = IDX_W + SLOT_W;
   // reciprocal of the alignment, exact for any PAY_W-bit sum and alignment up to 64
   localparam int RND_S = 28;
   localparam int RND_MW = 29;
   localparam int RND_W = PAY_W + RND_MW;
   localparam logic [RND_MW-1:0] RND_M =
      RND_MW'(((64'd1 << RND_S) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES));

   logic [31:0]        pool_base_ff;
   logic [23:0]        pool_bytes_ff;
   logic [20:0]        slot_stride_ff;

   logic [1:0]         op_ff;
   logic [31:0]        cnt_ff, size_ff, raddr_ff;
   logic [PAY_W-1:0]   rnd_q_ff;
   logic [PAY_W-1:0]   pay_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [31:0]        dist_ff, addr_ff;
   logic [IDX_W-1:0]   idx_ff, head_ff;
   logic               head_valid_ff;
   logic [23:0]        bump_offset_ff;
   logic [BS_W-1:0]    bump_slots_ff;
   logic [MUL_W-1:0]   prod2_ff;
   logic [IDX_W:0]     link_rd_ff;
   logic               mark_rd_ff;
   logic               rsp_valid_ff;
   logic [2:0]         rsp_status_ff;
   logic [31:0]        rsp_addr_ff;

   logic [IDX_W:0]     link_mem [MAX_SLOTS];
   logic               mark_mem [MAX_SLOTS];

   logic [SLOT_W-1:0]  slot;
   logic [24:0]        bump_next;
   logic [PAY_W-1:0]   rnd_sum;
   logic [RND_W-1:0]   rnd_prod;
   logic [DIV_W-1:0]   div_a, div_b, div_q, div_r;
   logic               div_busy, div_done;
   logic [IDX_W-1:0]   rel_idx;

   assign slot      = SLOT_W'(HDR) + SLOT_W'(pay_ff);
   assign bump_next = 25'(bump_offset_ff) + 25'(slot);
   assign rel_idx   = div_q[IDX_W-1:0];

   // stride plus alignment minus one, divided by the alignment
   assign rnd_sum  = PAY_W'(slot_stride_ff) + PAY_W'(ALIGN_BYTES - 1);
   assign rnd_prod = RND_W'(rnd_sum) * RND_W'(RND_M);

   assign div_a = dist_ff;
   assign div_b = DIV_W'(slot);

   fspa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   always_comb begin
      st              = '0;
      st.op           = op_ff;
      st.div_done     = div_done;
      st.req_bad      = cnt_ff[31] || (cnt_ff == '0) || size_ff[31] || (size_ff == '0);
      st.prod_fits    = prod_ff <= PROD_W'(pay_ff);
      st.head_valid   = head_valid_ff;
      st.bump_ok      = (bump_next <= 25'(pool_bytes_ff))
                        && (bump_slots_ff < BS_W'(MAX_SLOTS));
      st.ra_null      = (raddr_ff == '0);
      st.dist_outside = dist_ff >= 32'(bump_offset_ff);
      st.rem_nz       = (div_r != '0);
      st.idx_outside  = div_q >= 32'(bump_slots_ff);
      st.mark_set     = mark_rd_ff;
      st.out_free     = !rsp_valid_ff || rsp_tready;
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff   <= '0;
         pool_bytes_ff  <= '0;
         slot_stride_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            REG_POOL_BASE:   pool_base_ff   <= csr_data;
            REG_POOL_BYTES:  pool_bytes_ff  <= csr_data[23:0];
            REG_SLOT_STRIDE: slot_stride_ff <= csr_data[20:0];
            default: ;
         endcase
      end
   end

   // allocation state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff  <= 1'b0;
         bump_offset_ff <= '0;
         bump_slots_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd.clear) begin
            head_valid_ff  <= 1'b0;
            bump_offset_ff <= '0;
            bump_slots_ff  <= '0;
         end
         if (cmd.bump) begin
            bump_offset_ff <= bump_next[23:0];
            bump_slots_ff  <= bump_slots_ff + 1'b1;
         end
         if (cmd.pop) begin
            head_valid_ff <= link_rd_ff[IDX_W];
         end
         if (cmd.commit_rel) begin
            head_valid_ff <= 1'b1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff    <= req_tuser;
         cnt_ff   <= req_tdata[31:0];
         size_ff  <= req_tdata[63:32];
         raddr_ff <= req_tdata[95:64];
         addr_ff  <= '0;
      end
      if (cmd.load_rnd) begin
         rnd_q_ff <= rnd_prod[RND_S +: PAY_W];
      end
      if (cmd.load_pay) begin
         pay_ff <= PAY_W'(rnd_q_ff * PAY_W'(ALIGN_BYTES));
      end
      if (cmd.load_prod) begin
         prod_ff <= PROD_W'(cnt_ff[30:0]) * PROD_W'(size_ff[30:0]);
      end
      if (cmd.load_dist) begin
         dist_ff <= raddr_ff - 32'(HDR) - pool_base_ff;
      end
      if (cmd.bump) begin
         idx_ff <= bump_slots_ff[IDX_W-1:0];
      end
      if (cmd.pop) begin
         idx_ff  <= head_ff;
         head_ff <= link_rd_ff[IDX_W-1:0];
      end
      if (cmd.mark_read) begin
         idx_ff <= rel_idx;
      end
      if (cmd.commit_rel) begin
         head_ff <= idx_ff;
      end
      if (cmd.mul_addr) begin
         prod2_ff <= MUL_W'(idx_ff) * MUL_W'(slot);
      end
      if (cmd.load_addr) begin
         addr_ff <= pool_base_ff + 32'(prod2_ff) + 32'(HDR);
      end
      if (cmd.out_load) begin
         rsp_status_ff <= cmd.code;
         rsp_addr_ff   <= addr_ff;
      end
   end

   // per-slot stores
   always_ff @(posedge clock) begin
      if (cmd.head_read) begin
         link_rd_ff <= link_mem[head_ff];
      end
      if (cmd.write_alloc) begin
         link_mem[idx_ff] <= '0;
      end else if (cmd.commit_rel) begin
         link_mem[idx_ff] <= {head_valid_ff, head_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mark_read) begin
         mark_rd_ff <= mark_mem[rel_idx];
      end
      if (cmd.write_alloc) begin
         mark_mem[idx_ff] <= 1'b0;
      end else if (cmd.commit_rel) begin
         mark_mem[idx_ff] <= 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_addr_ff;

   a_head_below_bump: assert property (@(posedge clock) disable iff (reset)
      head_valid_ff |-> (BS_W'(head_ff) < bump_slots_ff))
      else $error("free list head beyond bumped slots");

   a_bump_limit: assert property (@(posedge clock) disable iff (reset)
      bump_slots_ff <= BS_W'(MAX_SLOTS))
      else $error("bump count above slot limit");

   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy)
      else $error("divider started while busy");

endmodule

[sv/fixed_slot_pool_allocator.sv]
`timescale 1ns / 1ps
// channel  dir  handshake            payload
// req      in   req_tvalid/tready    tuser: opcode; tdata: elem_count, elem_size, release_addr
// rsp      out  rsp_tvalid/tready    tuser: status; tdata: payload_addr
// csr      in   csr_valid/csr_ready  csr_index, csr_data (always ready)
//
// A transfer is accepted only in idle; slot_stride is rounded up by a reciprocal multiply.
// Every transfer passes the round and dispatch states, where clear and rejected requests end;
// a reserve then checks for space, pops the free list when it is used and forms the address;
// a release checks the used bytes, then waits on the serial divider and sets the free mark.
// Sync reset clears control, CSRs, bump state and the free list; slot stores need no clearing.
// A stalled result waits in the output register while the next transfer is accepted; the
// following result holds the block until the first one leaves.
module fixed_slot_pool_allocator #(
   parameter int MAX_SLOTS    = fspa_pkg::MAX_SLOTS_DEF,
   parameter int HEADER_BYTES = fspa_pkg::HEADER_BYTES_DEF,
   parameter int ALIGN_BYTES  = fspa_pkg::ALIGN_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   input  logic [95:0] req_tdata,   // [31:0] elem_count, [63:32] elem_size, [95:64] release_addr
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // [2:0] status
   output logic [31:0] rsp_tdata    // [31:0] payload_addr
);
   import fspa_pkg::*;

   cmd_type  cmd;
   stat_type st;

   // configuration writes are always accepted and go straight into the CSR registers
   assign csr_ready = 1'b1;

   fspa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   fspa_dp #(
      .MAX_SLOTS    (MAX_SLOTS),
      .HEADER_BYTES (HEADER_BYTES),
      .ALIGN_BYTES  (ALIGN_BYTES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .st         (st)
   );

endmodule
